// ===== rtl/core/apcd_pkg.sv =====
// Shared types and constants for the audio peak click detector.
// Used by every module of the block; depends on nothing else.
package apcd_pkg;

    // Sample format codes.
    localparam logic [1:0] FMT_U8  = 2'd0;
    localparam logic [1:0] FMT_S16 = 2'd1;
    localparam logic [1:0] FMT_S32 = 2'd2;
    localparam logic [1:0] FMT_F32 = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] REG_SAMPLE_FORMAT = 2'd0;
    localparam logic [1:0] REG_THRESHOLD     = 2'd1;
    localparam logic [1:0] REG_COOLDOWN_MS   = 2'd2;

    // Item kinds.
    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_TICK   = 1'b1;

    // Value limits and reset values.
    localparam logic [31:0] FULL_SCALE      = 32'h8000_0000;
    localparam logic [31:0] THR_MIN         = 32'd21474837;
    localparam logic [16:0] ELAPSED_MAX     = 17'h1_FFFF;
    localparam logic [1:0]  RST_FORMAT      = FMT_S16;
    localparam logic [31:0] RST_THRESHOLD   = 32'h4000_0000;
    localparam logic [15:0] RST_COOLDOWN_MS = 16'd300;

    // Float32 exponent that maps the hidden bit onto bit 23 + 0 of Q1.31.
    localparam logic [7:0] F32_EXP_ONE  = 8'd127;
    localparam logic [7:0] F32_EXP_BASE = 8'd119;
    localparam logic [7:0] F32_EXP_SPEC = 8'hFF;

    // Input item as it arrives on the port.
    typedef struct packed {
        logic        action;
        logic [31:0] sample_word;
        logic        last_of_chunk;
    } t_in_item;

    // Result item.
    typedef struct packed {
        logic [31:0] peak_level;
        logic        click;
    } t_out_item;

    // Classified item handed from the front to the back.
    typedef struct packed {
        logic        is_tick;
        logic [31:0] mag;
        logic        last;
    } t_dec_item;

    // Settings the back part needs.
    typedef struct packed {
        logic [31:0] threshold;
        logic [15:0] cooldown_ms;
    } t_back_cfg;

endpackage

// ===== rtl/core/apcd_front.sv =====
// Front part: accepts input items, decodes samples into Q1.31 magnitudes.
// Depends on apcd_pkg; feeds the item queue.
module apcd_front (
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  apcd_pkg::t_in_item   i_in_data,
    input  logic [1:0]           i_sample_format,
    output logic                 o_q_valid,
    input  logic                 i_q_ready,
    output apcd_pkg::t_dec_item  o_q_item
);
    import apcd_pkg::*;

    logic [31:0] w;
    logic [7:0]  u8_mag;
    logic [15:0] s16_mag;
    logic [31:0] s32_mag;
    logic [31:0] f32_mag;
    logic [7:0]  f_exp;
    logic [23:0] f_man;
    logic [7:0]  f_lsh;
    logic [7:0]  f_rsh;
    logic [31:0] mag;

    assign w = i_in_data.sample_word;

    // Integer formats: magnitude of the signed value.
    always_comb begin
        u8_mag  = w[7] ? (w[7:0] - 8'd128) : (8'd128 - w[7:0]);
        s16_mag = w[15] ? (16'd0 - w[15:0]) : w[15:0];
        s32_mag = w[31] ? (32'd0 - w) : w;
    end

    // Float32: saturate at one, NaN reads as zero, subnormals truncate to zero.
    always_comb begin
        f_exp = w[30:23];
        f_man = {1'b1, w[22:0]};
        f_lsh = f_exp - F32_EXP_BASE;
        f_rsh = F32_EXP_BASE - f_exp;
        if (f_exp == F32_EXP_SPEC) begin
            f32_mag = (w[22:0] != 23'd0) ? 32'd0 : FULL_SCALE;
        end else if (f_exp >= F32_EXP_ONE) begin
            f32_mag = FULL_SCALE;
        end else if (f_exp == 8'd0) begin
            f32_mag = 32'd0;
        end else if (f_exp >= F32_EXP_BASE) begin
            f32_mag = {8'd0, f_man} << f_lsh[2:0];
        end else if (f_rsh >= 8'd32) begin
            f32_mag = 32'd0;
        end else begin
            f32_mag = {8'd0, f_man} >> f_rsh[4:0];
        end
    end

    // Select the decoder for the configured format.
    always_comb begin
        case (i_sample_format)
            FMT_U8:  mag = {u8_mag, 24'd0};
            FMT_S16: mag = {s16_mag, 16'd0};
            FMT_S32: mag = s32_mag;
            FMT_F32: mag = f32_mag;
            default: mag = 32'd0;
        endcase
    end

    // Every transfer goes straight into the queue.
    assign o_in_ready       = i_q_ready;
    assign o_q_valid        = i_in_valid;
    assign o_q_item.is_tick = (i_in_data.action == ACT_TICK);
    assign o_q_item.mag     = mag;
    assign o_q_item.last    = i_in_data.last_of_chunk;

endmodule

// ===== rtl/core/apcd_queue.sv =====
// Short queue of decoded items between the front and the back part.
// Depends on apcd_pkg for the item type.
module apcd_queue #(
    parameter int DEPTH = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  apcd_pkg::t_dec_item  i_push_item,
    output logic                 o_not_full,
    input  logic                 i_pop,
    output logic                 o_not_empty,
    output apcd_pkg::t_dec_item  o_head
);
    import apcd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_dec_item          r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wptr, n_wptr;
    logic [PTR_W-1:0]   r_rptr, n_rptr;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               do_push;
    logic               do_pop;

    assign o_not_full  = (r_count != CNT_W'(DEPTH));
    assign o_not_empty = (r_count != '0);
    assign o_head      = r_mem[r_rptr];
    assign do_push     = i_push && o_not_full;
    assign do_pop      = i_pop && o_not_empty;

    // Pointer and fill count update.
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push) begin
            n_wptr = (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (do_pop) begin
            n_rptr = (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_push_item;
        end
    end

endmodule

// ===== rtl/core/apcd_back.sv =====
// Back part: keeps the chunk peak and elapsed time, decides clicks.
// Depends on apcd_pkg; drives the result output register.
module apcd_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  apcd_pkg::t_back_cfg  i_cfg,
    input  logic                 i_head_valid,
    input  apcd_pkg::t_dec_item  i_head,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output apcd_pkg::t_out_item  o_out_data
);
    import apcd_pkg::*;

    logic [31:0] r_peak, n_peak;
    logic [16:0] r_elapsed, n_elapsed;
    logic        r_out_valid, n_out_valid;
    t_out_item   r_out;
    logic        makes_result;
    logic        out_free;
    logic [31:0] chunk_peak;
    logic        fire;

    // Only a closing sample makes a result; others never wait on the output.
    assign makes_result = !i_head.is_tick && i_head.last;
    assign out_free     = !r_out_valid || i_out_ready;
    assign o_pop        = i_head_valid && (!makes_result || out_free);

    assign chunk_peak = (i_head.mag > r_peak) ? i_head.mag : r_peak;
    assign fire       = (chunk_peak >= i_cfg.threshold)
                     && (r_elapsed >= {1'b0, i_cfg.cooldown_ms});

    // State update for the popped item.
    always_comb begin
        n_peak    = r_peak;
        n_elapsed = r_elapsed;
        if (o_pop) begin
            if (i_head.is_tick) begin
                if (r_elapsed != ELAPSED_MAX) begin
                    n_elapsed = r_elapsed + 1'b1;
                end
            end else if (i_head.last) begin
                n_peak = 32'd0;
                if (fire) begin
                    n_elapsed = 17'd0;
                end
            end else begin
                n_peak = chunk_peak;
            end
        end
    end

    // Output register holds a result until its transfer.
    assign n_out_valid = (r_out_valid && !i_out_ready) || (o_pop && makes_result);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak      <= 32'd0;
            r_elapsed   <= ELAPSED_MAX;
            r_out_valid <= 1'b0;
        end else begin
            r_peak      <= n_peak;
            r_elapsed   <= n_elapsed;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && makes_result) begin
            r_out.peak_level <= chunk_peak;
            r_out.click      <= fire;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== rtl/core/audio_peak_click_detector.sv =====
// Audio peak click detector: decodes samples, tracks chunk peaks, fires clicks.
// A closing sample's result is registered in the output register after passing through the item queue.
// Throughput: one item per cycle while the queue has room; a stalled result output holds closing samples.
// The queue absorbs up to QUEUE_DEPTH items while the result output stalls.
// Reset (synchronous, active low) empties the queue and output, clears the peak,
// saturates elapsed time and loads format 16-bit, threshold 0.5, cooldown 300.
module audio_peak_click_detector #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  apcd_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output apcd_pkg::t_out_item  o_out_data,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [31:0]          i_cfg_data
);
    import apcd_pkg::*;

    logic [1:0]  r_sample_format;
    logic [31:0] r_threshold;
    logic [15:0] r_cooldown_ms;
    logic [31:0] thr_clamped;
    t_back_cfg   back_cfg;
    logic        q_push;
    logic        q_not_full;
    logic        q_not_empty;
    logic        q_pop;
    t_dec_item   q_push_item;
    t_dec_item   q_head;

    // Threshold writes are clamped into 0.01 .. 1.0.
    assign thr_clamped = (i_cfg_data < THR_MIN) ? THR_MIN :
                         (i_cfg_data > FULL_SCALE) ? FULL_SCALE : i_cfg_data;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_format <= RST_FORMAT;
            r_threshold     <= RST_THRESHOLD;
            r_cooldown_ms   <= RST_COOLDOWN_MS;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_SAMPLE_FORMAT: r_sample_format <= i_cfg_data[1:0];
                REG_THRESHOLD:     r_threshold     <= thr_clamped;
                REG_COOLDOWN_MS:   r_cooldown_ms   <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    assign back_cfg.threshold   = r_threshold;
    assign back_cfg.cooldown_ms = r_cooldown_ms;

    apcd_front u_front (
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_in_data       (i_in_data),
        .i_sample_format (r_sample_format),
        .o_q_valid       (q_push),
        .i_q_ready       (q_not_full),
        .o_q_item        (q_push_item)
    );

    apcd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_item (q_push_item),
        .o_not_full  (q_not_full),
        .i_pop       (q_pop),
        .o_not_empty (q_not_empty),
        .o_head      (q_head)
    );

    apcd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (back_cfg),
        .i_head_valid (q_not_empty),
        .i_head       (q_head),
        .o_pop        (q_pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_data   (o_out_data)
    );

`ifndef SYNTHESIS
    // The stored threshold never leaves its legal range.
    a_thr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_threshold >= THR_MIN) && (r_threshold <= FULL_SCALE))
        else $error("threshold register out of range");

    // A reported peak never exceeds full scale.
    a_peak_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.peak_level <= FULL_SCALE))
        else $error("peak level above full scale");

    // A click is only reported for a peak at or above the threshold.
    a_click_thr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.click) |-> (o_out_data.peak_level >= r_threshold))
        else $error("click below threshold");

    // The queue is popped only when it holds an item.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_not_empty)
        else $error("queue popped while empty");
`endif

endmodule
